[design/rset_pkg.sv]
// Shared constants, codes and interface types for the randomized set table.
`default_nettype none

package rset_pkg;

   localparam int CAPACITY   = 64;
   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int VALUE_W    = 32;
   localparam int RAND_W     = 16;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 3;
   localparam int RAND_CNT_W = $clog2(RAND_W + 1);

   localparam logic [OP_W-1:0] OP_INSERT = OP_W'(0);
   localparam logic [OP_W-1:0] OP_REMOVE = OP_W'(1);
   localparam logic [OP_W-1:0] OP_DRAW   = OP_W'(2);

   localparam logic [STATUS_W-1:0] ST_DONE    = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_PRESENT = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_ABSENT  = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] ST_FULL    = STATUS_W'(3);
   localparam logic [STATUS_W-1:0] ST_EMPTY   = STATUS_W'(4);

   typedef struct packed {
      logic              start;
      logic [RAND_W-1:0] dividend;
      logic [CNT_W-1:0]  divisor;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] remainder;
   } mod_rsp_type;

   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  member;
   } result_type;

endpackage

`default_nettype wire

[design/rset_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rset_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/rset_mod.sv]
// Bit-serial remainder unit: one restoring step per cycle over the dividend.
`default_nettype none

module rset_mod (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rset_pkg::mod_req_type req,
   output rset_pkg::mod_rsp_type     rsp
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [rset_pkg::RAND_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [rset_pkg::RAND_W-1:0]      quo_ff, quo_in;
   logic [rset_pkg::CNT_W-1:0]       rem_ff, rem_in;
   logic [rset_pkg::CNT_W-1:0]       div_ff, div_in;
   logic [rset_pkg::CNT_W:0]         shifted;
   logic [rset_pkg::CNT_W-1:0]       rem_step;

   always_comb begin
      shifted  = {rem_ff, quo_ff[rset_pkg::RAND_W-1]};
      if (shifted >= {1'b0, div_ff}) begin
         rem_step = rset_pkg::CNT_W'(shifted - {1'b0, div_ff});
      end else begin
         rem_step = shifted[rset_pkg::CNT_W-1:0];
      end

      busy_in    = busy_ff;
      done_in    = 1'b0;
      bit_cnt_in = bit_cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;

      if (req.start) begin
         busy_in    = 1'b1;
         bit_cnt_in = rset_pkg::RAND_CNT_W'(rset_pkg::RAND_W);
         quo_in     = req.dividend;
         rem_in     = '0;
         div_in     = req.divisor;
      end else if (busy_ff) begin
         rem_in     = rem_step;
         quo_in     = {quo_ff[rset_pkg::RAND_W-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - rset_pkg::RAND_CNT_W'(1);
         if (bit_cnt_ff == rset_pkg::RAND_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         done_ff    <= 1'b0;
         bit_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         done_ff    <= done_in;
         bit_cnt_ff <= bit_cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

`default_nettype wire

[design/rset_seq.sv]
// Operation sequencer: slot search, insert, remove with last-slot move, and draw.
`default_nettype none

module rset_seq (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [rset_pkg::OP_W-1:0]        req_op,
   input  wire logic [rset_pkg::VALUE_W-1:0]     req_value,
   input  wire logic [rset_pkg::RAND_W-1:0]      req_rand,
   input  wire logic                             out_free,
   output rset_pkg::result_type                  result,
   output rset_pkg::mod_req_type                 mod_req,
   input  wire rset_pkg::mod_rsp_type            mod_rsp,
   output logic                                  ram_wr_en,
   output logic [rset_pkg::IDX_W-1:0]            ram_wr_addr,
   output logic [rset_pkg::VALUE_W-1:0]          ram_wr_data,
   output logic [rset_pkg::IDX_W-1:0]            ram_rd_addr,
   input  wire logic [rset_pkg::VALUE_W-1:0]     ram_rd_data
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_SEARCH    = 3'd1;
   localparam logic [2:0] S_MOD       = 3'd2;
   localparam logic [2:0] S_DRAW_RD   = 3'd3;
   localparam logic [2:0] S_DRAW_DATA = 3'd4;
   localparam logic [2:0] S_LAST_RD   = 3'd5;
   localparam logic [2:0] S_LAST_WR   = 3'd6;
   localparam logic [2:0] S_DONE      = 3'd7;

   logic [2:0]                      state_ff, state_in;
   logic [rset_pkg::OP_W-1:0]       op_ff, op_in;
   logic [rset_pkg::VALUE_W-1:0]    value_ff, value_in;
   logic [rset_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [rset_pkg::CNT_W-1:0]      scan_ff, scan_in;
   logic                            pend_ff, pend_in;
   logic [rset_pkg::IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic [rset_pkg::IDX_W-1:0]      pos_ff, pos_in;
   logic [rset_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [rset_pkg::VALUE_W-1:0]    member_ff, member_in;

   logic                            accept;
   logic                            issue;
   logic                            hit;
   logic [rset_pkg::CNT_W-1:0]      last_idx;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign issue     = (scan_ff < count_ff);
   assign hit       = pend_ff && (ram_rd_data == value_ff);
   assign last_idx  = count_ff - rset_pkg::CNT_W'(1);

   always_comb begin
      case (state_ff)
         S_DRAW_RD: ram_rd_addr = pos_ff;
         S_LAST_RD: ram_rd_addr = last_idx[rset_pkg::IDX_W-1:0];
         default:   ram_rd_addr = scan_ff[rset_pkg::IDX_W-1:0];
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      value_in    = value_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      pos_in      = pos_ff;
      status_in   = status_ff;
      member_in   = member_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[rset_pkg::IDX_W-1:0];
      ram_wr_data = value_ff;

      mod_req.start    = 1'b0;
      mod_req.dividend = req_rand;
      mod_req.divisor  = count_ff;

      result.valid  = 1'b0;
      result.status = status_ff;
      result.member = member_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               value_in  = req_value;
               scan_in   = '0;
               pend_in   = 1'b0;
               status_in = rset_pkg::ST_DONE;
               member_in = '0;
               if (req_op == rset_pkg::OP_INSERT || req_op == rset_pkg::OP_REMOVE) begin
                  state_in = S_SEARCH;
               end else if (req_op == rset_pkg::OP_DRAW) begin
                  if (count_ff == '0) begin
                     status_in = rset_pkg::ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     mod_req.start = 1'b1;
                     state_in      = S_MOD;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SEARCH: begin
            // One slot read is issued per cycle; its data is compared in the next cycle.
            if (hit) begin
               if (op_ff == rset_pkg::OP_INSERT) begin
                  status_in = rset_pkg::ST_PRESENT;
                  state_in  = S_DONE;
               end else begin
                  pos_in   = pend_idx_ff;
                  state_in = S_LAST_RD;
               end
            end else if (!issue && !pend_ff) begin
               if (op_ff == rset_pkg::OP_INSERT) begin
                  if (count_ff == rset_pkg::CNT_W'(rset_pkg::CAPACITY)) begin
                     status_in = rset_pkg::ST_FULL;
                  end else begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + rset_pkg::CNT_W'(1);
                  end
               end else begin
                  status_in = rset_pkg::ST_ABSENT;
               end
               state_in = S_DONE;
            end else begin
               pend_in     = issue;
               pend_idx_in = scan_ff[rset_pkg::IDX_W-1:0];
               if (issue) begin
                  scan_in = scan_ff + rset_pkg::CNT_W'(1);
               end
            end
         end
         S_MOD: begin
            if (mod_rsp.done) begin
               pos_in   = mod_rsp.remainder[rset_pkg::IDX_W-1:0];
               state_in = S_DRAW_RD;
            end
         end
         S_DRAW_RD: begin
            state_in = S_DRAW_DATA;
         end
         S_DRAW_DATA: begin
            member_in = ram_rd_data;
            state_in  = S_DONE;
         end
         S_LAST_RD: begin
            state_in = S_LAST_WR;
         end
         S_LAST_WR: begin
            // The last occupied slot fills the hole left by the removed value.
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff;
            ram_wr_data = ram_rd_data;
            count_in    = last_idx;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               result.valid = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      op_ff       <= op_in;
      value_ff    <= value_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      member_ff   <= member_in;
   end

endmodule

`default_nettype wire

[design/randomized_set_table_core.sv]
// Randomized set table: top level with slot RAM, remainder unit, sequencer, response register.
// Insert and remove are paced by the search, which reads one slot per cycle from the RAM,
// and a draw by the 16-step bit-serial remainder unit.
// One request is in work at a time; a finished response may wait while the next is taken.
// Synchronous active-high reset empties the set; slot contents are not cleared.
`default_nettype none

module randomized_set_table_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // [31:0] value, [47:32] random_word
   input  wire logic [1:0]  req_tuser,  // [1:0] operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // [31:0] member
   output logic [2:0]       rsp_tuser   // [2:0] status
);

   rset_pkg::result_type             result;
   rset_pkg::mod_req_type            mod_req;
   rset_pkg::mod_rsp_type            mod_rsp;
   logic                             ram_wr_en;
   logic [rset_pkg::IDX_W-1:0]       ram_wr_addr;
   logic [rset_pkg::VALUE_W-1:0]     ram_wr_data;
   logic [rset_pkg::IDX_W-1:0]       ram_rd_addr;
   logic [rset_pkg::VALUE_W-1:0]     ram_rd_data;
   logic                             out_free;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rset_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic [rset_pkg::VALUE_W-1:0]     rsp_member_ff;

   rset_ram #(
      .WIDTH (rset_pkg::VALUE_W),
      .DEPTH (rset_pkg::CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rset_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   rset_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_value   (req_tdata[31:0]),
      .req_rand    (req_tdata[47:32]),
      .out_free    (out_free),
      .result      (result),
      .mod_req     (mod_req),
      .mod_rsp     (mod_rsp),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // The response register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (result.valid) begin
         rsp_status_ff <= result.status;
         rsp_member_ff <= result.member;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_member_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

[design/rset_checker.sv]
// Port-level checks for the randomized set table, bound to the top level.
`default_nettype none

module rset_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [47:0] req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response pending after reset");

   // Every request moves the sequencer out of idle, so the block is busy right after taking one.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken on consecutive cycles");

   // Only a successful operation can carry a member.
   a_member_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != rset_pkg::ST_DONE) |-> rsp_tdata == '0)
      else $error("nonzero member on a failed request");

endmodule

bind randomized_set_table_core rset_checker u_checker (.*);

`default_nettype wire
